/* sv/lmfe_pkg.sv */
// ----------------------------------------------------------------------------
// lmfe_pkg
// Shared types, command codes and bit helpers for the LED frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lmfe_pkg;

    localparam int unsigned ROWS = 8;

    // command codes
    localparam logic [3:0] KIND_PIXEL   = 4'd0;
    localparam logic [3:0] KIND_ROW     = 4'd1;
    localparam logic [3:0] KIND_COLUMN  = 4'd2;
    localparam logic [3:0] KIND_LOAD    = 4'd3;
    localparam logic [3:0] KIND_SHL     = 4'd4;
    localparam logic [3:0] KIND_SHR     = 4'd5;
    localparam logic [3:0] KIND_ROTL    = 4'd6;
    localparam logic [3:0] KIND_ROTR    = 4'd7;
    localparam logic [3:0] KIND_INVERT  = 4'd8;
    localparam logic [3:0] KIND_TURN_L  = 4'd9;
    localparam logic [3:0] KIND_TURN_R  = 4'd10;
    localparam logic [3:0] KIND_SWAP    = 4'd11;
    localparam logic [3:0] KIND_MIRROR  = 4'd12;
    localparam logic [3:0] KIND_CLEAR   = 4'd13;
    localparam logic [3:0] KIND_REFRESH = 4'd14;

    localparam logic [3:0] LAST_ADDRESS = 4'd8;

    // eight row bytes, element i is row i
    typedef logic [ROWS-1:0][7:0] t_frame;

    // command word
    typedef struct packed {
        logic [3:0]  kind;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [63:0] payload;
    } t_cmd;

    // digit-register write word
    typedef struct packed {
        logic [3:0] digit_address;
        logic [7:0] row_bits;
        logic       last;
    } t_word;

    // bit reversal of one row byte
    function automatic logic [7:0] mirror_byte(input logic [7:0] b);
        logic [7:0] t;
        t = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
        t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
        t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
        return t;
    endfunction

endpackage

`default_nettype wire

/* sv/lmfe_frame_alu.sv */
// ----------------------------------------------------------------------------
// lmfe_frame_alu
// Combinational frame edit: applies one command to the current frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfe_frame_alu (
    input  wire lmfe_pkg::t_frame i_frame,
    input  wire lmfe_pkg::t_cmd   i_cmd,
    output lmfe_pkg::t_frame      o_frame,
    output logic                  o_known
);
    import lmfe_pkg::*;

    logic [7:0] low;
    logic [7:0] cmask;
    t_frame     nf;

    assign low   = i_cmd.payload[7:0];
    assign cmask = 8'h80 >> i_cmd.col;

    // per-command frame update
    always_comb begin
        nf = i_frame;
        case (i_cmd.kind)
            KIND_PIXEL: begin
                if (low != 8'h00) begin
                    nf[i_cmd.row] = i_frame[i_cmd.row] | cmask;
                end else begin
                    nf[i_cmd.row] = i_frame[i_cmd.row] & ~cmask;
                end
            end
            KIND_ROW: begin
                nf[i_cmd.row] = low;
            end
            KIND_COLUMN: begin
                for (int i = 0; i < ROWS; i++) begin
                    nf[i] = (i_frame[i] & ~cmask) | (low[7-i] ? cmask : 8'h00);
                end
            end
            KIND_LOAD: begin
                for (int i = 0; i < ROWS; i++) begin
                    nf[i] = i_cmd.payload[8*(7-i) +: 8];
                end
            end
            KIND_SHL: begin
                for (int i = 0; i < ROWS; i++) begin
                    nf[i] = {i_frame[i][6:0], 1'b0};
                end
            end
            KIND_SHR: begin
                for (int i = 0; i < ROWS; i++) begin
                    nf[i] = {1'b0, i_frame[i][7:1]};
                end
            end
            KIND_ROTL: begin
                for (int i = 0; i < ROWS; i++) begin
                    nf[i] = {i_frame[i][6:0], i_frame[i][7]};
                end
            end
            KIND_ROTR: begin
                for (int i = 0; i < ROWS; i++) begin
                    nf[i] = {i_frame[i][0], i_frame[i][7:1]};
                end
            end
            KIND_INVERT: begin
                nf = ~i_frame;
            end
            KIND_TURN_L: begin
                // new row j, bit 7-i takes old row i, bit j
                for (int i = 0; i < ROWS; i++) begin
                    for (int j = 0; j < ROWS; j++) begin
                        nf[j][7-i] = i_frame[i][j];
                    end
                end
            end
            KIND_TURN_R: begin
                // new row 7-j, bit i takes old row i, bit j
                for (int i = 0; i < ROWS; i++) begin
                    for (int j = 0; j < ROWS; j++) begin
                        nf[7-j][i] = i_frame[i][j];
                    end
                end
            end
            KIND_SWAP: begin
                for (int i = 0; i < ROWS; i++) begin
                    nf[i] = i_frame[7-i];
                end
            end
            KIND_MIRROR: begin
                for (int i = 0; i < ROWS; i++) begin
                    nf[i] = mirror_byte(i_frame[i]);
                end
            end
            KIND_CLEAR: begin
                nf = '0;
            end
            default: begin
                nf = i_frame;
            end
        endcase
    end

    assign o_frame = nf;
    // unused code 15 does nothing at all
    assign o_known = (i_cmd.kind <= KIND_REFRESH);

endmodule

`default_nettype wire

/* sv/led_matrix_frame_engine_unit.sv */
// ----------------------------------------------------------------------------
// led_matrix_frame_engine_unit
// 8x8 LED frame buffer with edit commands and eight-word row write-out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     word
//  command   in         i_cmd_valid / o_cmd_ready     i_cmd  (t_cmd)
//  row write out        o_wr_valid  / i_wr_ready      o_word (t_word)
//  config    in         i_cfg_we (no wait)            i_cfg_wdata
//
//  A command edits the frame in the cycle it is accepted (one register stage).
//  An emitting command copies the new frame into an output shift register
//  that sends eight words, one per cycle when i_wr_ready is high.
//  The command port stalls while those eight words drain, taking the next
//  command in the cycle the eighth word leaves.
//  Reset clears the frame, the write-out and sets auto_update to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_frame_engine_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cmd_valid,
    output logic                 o_cmd_ready,
    input  wire lmfe_pkg::t_cmd  i_cmd,
    output logic                 o_wr_valid,
    input  wire                  i_wr_ready,
    output lmfe_pkg::t_word      o_word,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_wdata
);
    import lmfe_pkg::*;

    t_frame     r_frame;
    t_frame     n_frame;
    t_frame     r_snap;
    t_frame     n_snap;
    logic       r_busy;
    logic       n_busy;
    logic [2:0] r_idx;
    logic [2:0] n_idx;
    logic       r_auto;

    t_frame     alu_frame;
    logic       alu_known;
    logic       cmd_acc;
    logic       wr_acc;
    logic       emit;
    logic       last_out;

    // frame edit logic
    lmfe_frame_alu u_alu (
        .i_frame (r_frame),
        .i_cmd   (i_cmd),
        .o_frame (alu_frame),
        .o_known (alu_known)
    );

    // handshakes
    assign last_out    = (r_idx == 3'd7);
    assign wr_acc      = o_wr_valid && i_wr_ready;
    assign o_cmd_ready = !r_busy || (wr_acc && last_out);
    assign cmd_acc     = i_cmd_valid && o_cmd_ready;
    assign emit        = alu_known && ((i_cmd.kind == KIND_REFRESH) || r_auto);

    // next frame and write-out state
    always_comb begin
        n_frame = r_frame;
        n_snap  = r_snap;
        n_busy  = r_busy;
        n_idx   = r_idx;
        if (wr_acc) begin
            n_snap = t_frame'({8'h00, r_snap[ROWS-1:1]});
            n_idx  = r_idx + 3'd1;
            if (last_out) begin
                n_busy = 1'b0;
            end
        end
        if (cmd_acc) begin
            n_frame = alu_frame;
            if (emit) begin
                n_snap = alu_frame;
                n_idx  = 3'd0;
                n_busy = 1'b1;
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_busy  <= 1'b0;
            r_idx   <= 3'd0;
            r_auto  <= 1'b1;
        end else begin
            r_frame <= n_frame;
            r_busy  <= n_busy;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                r_auto <= i_cfg_wdata;
            end
        end
    end

    // snapshot needs no reset
    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
    end

    // output word
    assign o_wr_valid           = r_busy;
    assign o_word.digit_address = {1'b0, r_idx} + 4'd1;
    assign o_word.row_bits      = r_snap[0];
    assign o_word.last          = last_out;

`ifndef NO_ASSERTIONS
    // the last flag marks the eighth digit exactly
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_valid |-> (o_word.last == (o_word.digit_address == LAST_ADDRESS)))
        else $error("last flag and digit address disagree");

    // an emitting command starts a group at digit one
    a_group_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && emit) |=> (o_wr_valid && o_word.digit_address == 4'd1))
        else $error("group did not start at digit one");

    // commands wait while a group drains, but for its final word
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && o_cmd_ready) |-> (i_wr_ready && last_out))
        else $error("command taken while a group is draining");

    // reset leaves a blank frame and auto update on
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_frame == '0 && r_auto && !o_wr_valid))
        else $error("reset state wrong");
`endif

endmodule

`default_nettype wire
